/* rtl/omni_drive_mixer_defines.svh */
// assertion macros of the omni drive mixer, used by odm_ctrl
`ifndef OMNI_DRIVE_MIXER_DEFINES_SVH
`define OMNI_DRIVE_MIXER_DEFINES_SVH

// same-cycle implication on clk_i, quiet during reset
`define ODM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication on clk_i, quiet during reset
`define ODM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/odm_pkg.sv */
// types, constants and codes of the omni drive mixer
`timescale 1ns / 1ps
package odm_pkg;

  // full-scale wheel current
  localparam logic [14:0] FULL_SCALE = 15'd16384;

  // arithmetic constants
  localparam logic [21:0] DEN_SPIN   = 22'd2550000;
  localparam logic [19:0] SQRT_SCALE = 20'd1000000;
  localparam logic [15:0] D2_MIN     = 16'd16129;
  localparam logic [6:0]  PCT_FULL   = 7'd100;
  localparam logic [6:0]  RAMP_MAX   = 7'd100;

  // datapath widths and iteration counts
  localparam int NUM_W     = 62;
  localparam int DEN_W     = 45;
  localparam int SQ_W      = 50;
  localparam int QUO_W     = 15;
  localparam int SQ_STEPS  = 25;
  localparam int DIV_STEPS = 15;

  // drive mode codes
  localparam logic [2:0] MODE_STOP   = 3'd0;
  localparam logic [2:0] MODE_RSPIN  = 3'd1;
  localparam logic [2:0] MODE_LSPIN  = 3'd2;
  localparam logic [2:0] MODE_TRANS  = 3'd3;
  localparam logic [2:0] MODE_DISC   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_STICK_DZ   = 3'd0;
  localparam logic [2:0] CFG_TRIG_DZ    = 3'd1;
  localparam logic [2:0] CFG_TURN_PWR   = 3'd2;
  localparam logic [2:0] CFG_PWR_NORM   = 3'd3;
  localparam logic [2:0] CFG_PWR_BOOST  = 3'd4;
  localparam logic [2:0] CFG_SLOW       = 3'd5;
  localparam logic [2:0] CFG_RAMP_STEP  = 3'd6;
  localparam logic [2:0] CFG_RAMP_DEF   = 3'd7;

  typedef struct packed {
    logic [7:0] stick_dz;
    logic [7:0] trig_dz;
    logic [6:0] turn_pwr;
    logic [6:0] pwr_norm;
    logic [6:0] pwr_boost;
    logic [6:0] slow_factor;
    logic [6:0] ramp_step;
    logic [6:0] ramp_default;
  } cfg_t;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MS_XX,
    MS_YY,
    MS_K1,
    MS_KS,
    MS_KA,
    MS_KB,
    MS_NUM,
    MS_DEN
  } mul_sel_e;

  // request class after deadzones
  typedef enum logic [1:0] {
    KIND_DISC,
    KIND_STOP,
    KIND_SPIN,
    KIND_TRANS
  } kind_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     sq_init;
    logic     sq_step;
    logic     div_init;
    logic     div_step;
    logic     save_a;
    logic     save_b;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  out_free;
  } sts_t;

endpackage

/* rtl/omni_drive_mixer.sv */
// Four-wheel omni drive mixer: gamepad request in, four wheel currents out.
// Input channel: in_valid_i/in_ready_o with one port per gamepad field;
// a request is taken when both are high, only while the block is idle.
// Output channel: out_valid_o/out_ready_i with the four wheel currents and
// drive_mode_o, held in a result register until taken.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i,
// always ready; write only while no request is in flight.
// The next request is accepted in the cycle after the result is loaded.
// A translation runs the 25-step bit-serial square root and two 15-step
// restoring divisions, a spin one division, stop and disconnect neither;
// all products come from one multiplier shared in the datapath.
// A stalled receiver holds the result register; the block finishes the
// following request and then waits before loading its result.
// Reset clears the ramp to zero, selects normal power, empties the result
// register and restores all configuration registers to their defaults.
`timescale 1ns / 1ps
module omni_drive_mixer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               connected_i,
  input  logic signed [7:0]  stick_x_i,
  input  logic signed [7:0]  stick_y_i,
  input  logic [7:0]         right_trigger_i,
  input  logic [7:0]         left_trigger_i,
  input  logic               slow_button_i,
  input  logic               boost_up_button_i,
  input  logic               boost_down_button_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] motor1_current_o,
  output logic signed [15:0] motor2_current_o,
  output logic signed [15:0] motor3_current_o,
  output logic signed [15:0] motor4_current_o,
  output logic [2:0]         drive_mode_o
);

  odm_pkg::cfg_t cfg_q;
  odm_pkg::cmd_t cmd;
  odm_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stick_dz     <= 8'd40;
      cfg_q.trig_dz      <= 8'd40;
      cfg_q.turn_pwr     <= 7'd30;
      cfg_q.pwr_norm     <= 7'd70;
      cfg_q.pwr_boost    <= 7'd100;
      cfg_q.slow_factor  <= 7'd30;
      cfg_q.ramp_step    <= 7'd1;
      cfg_q.ramp_default <= 7'd25;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        odm_pkg::CFG_STICK_DZ:  cfg_q.stick_dz     <= cfg_data_i;
        odm_pkg::CFG_TRIG_DZ:   cfg_q.trig_dz      <= cfg_data_i;
        odm_pkg::CFG_TURN_PWR:  cfg_q.turn_pwr     <= cfg_data_i[6:0];
        odm_pkg::CFG_PWR_NORM:  cfg_q.pwr_norm     <= cfg_data_i[6:0];
        odm_pkg::CFG_PWR_BOOST: cfg_q.pwr_boost    <= cfg_data_i[6:0];
        odm_pkg::CFG_SLOW:      cfg_q.slow_factor  <= cfg_data_i[6:0];
        odm_pkg::CFG_RAMP_STEP: cfg_q.ramp_step    <= cfg_data_i[6:0];
        odm_pkg::CFG_RAMP_DEF:  cfg_q.ramp_default <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // sequencer
  odm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  odm_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .connected_i         (connected_i),
    .stick_x_i           (stick_x_i),
    .stick_y_i           (stick_y_i),
    .right_trigger_i     (right_trigger_i),
    .left_trigger_i      (left_trigger_i),
    .slow_button_i       (slow_button_i),
    .boost_up_button_i   (boost_up_button_i),
    .boost_down_button_i (boost_down_button_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .motor1_current_o    (motor1_current_o),
    .motor2_current_o    (motor2_current_o),
    .motor3_current_o    (motor3_current_o),
    .motor4_current_o    (motor4_current_o),
    .drive_mode_o        (drive_mode_o)
  );

endmodule

/* rtl/odm_ctrl.sv */
// sequencing state machine of the omni drive mixer
`timescale 1ns / 1ps
`include "omni_drive_mixer_defines.svh"
module odm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  odm_pkg::sts_t sts_i,
  output odm_pkg::cmd_t cmd_o
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DECIDE = 5'd1;
  localparam logic [4:0] ST_XX     = 5'd2;
  localparam logic [4:0] ST_YY     = 5'd3;
  localparam logic [4:0] ST_SQI    = 5'd4;
  localparam logic [4:0] ST_SQ     = 5'd5;
  localparam logic [4:0] ST_DEN    = 5'd6;
  localparam logic [4:0] ST_K1     = 5'd7;
  localparam logic [4:0] ST_KS     = 5'd8;
  localparam logic [4:0] ST_KA     = 5'd9;
  localparam logic [4:0] ST_NUMA   = 5'd10;
  localparam logic [4:0] ST_DIA    = 5'd11;
  localparam logic [4:0] ST_DVA    = 5'd12;
  localparam logic [4:0] ST_SVA    = 5'd13;
  localparam logic [4:0] ST_KB     = 5'd14;
  localparam logic [4:0] ST_NUMB   = 5'd15;
  localparam logic [4:0] ST_DIB    = 5'd16;
  localparam logic [4:0] ST_DVB    = 5'd17;
  localparam logic [4:0] ST_SVB    = 5'd18;
  localparam logic [4:0] ST_FIN    = 5'd19;

  logic [4:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       spin;

  assign spin       = (sts_i.kind == odm_pkg::KIND_SPIN);
  assign in_ready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    cmd_o.mul_sel  = odm_pkg::MS_XX;
    cmd_o.load     = in_valid_i && (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        unique case (sts_i.kind)
          odm_pkg::KIND_SPIN:  state_d = ST_DEN;
          odm_pkg::KIND_TRANS: state_d = ST_XX;
          default:             state_d = ST_FIN;
        endcase
      end
      ST_XX: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = odm_pkg::MS_XX; state_d = ST_YY;
      end
      ST_YY: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = odm_pkg::MS_YY; state_d = ST_SQI;
      end
      ST_SQI: begin
        cmd_o.sq_init = 1'b1; cnt_d = '0; state_d = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.sq_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(odm_pkg::SQ_STEPS - 1)) begin
          cnt_d = '0; state_d = ST_DEN;
        end
      end
      ST_DEN: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = odm_pkg::MS_DEN; state_d = ST_K1;
      end
      ST_K1: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = odm_pkg::MS_K1; state_d = ST_KS;
      end
      ST_KS: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = odm_pkg::MS_KS;
        state_d = spin ? ST_NUMA : ST_KA;
      end
      ST_KA: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = odm_pkg::MS_KA; state_d = ST_NUMA;
      end
      ST_NUMA: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = odm_pkg::MS_NUM; state_d = ST_DIA;
      end
      ST_DIA: begin
        cmd_o.div_init = 1'b1; cnt_d = '0; state_d = ST_DVA;
      end
      ST_DVA: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(odm_pkg::DIV_STEPS - 1)) begin
          cnt_d = '0; state_d = ST_SVA;
        end
      end
      ST_SVA: begin
        cmd_o.save_a = 1'b1; state_d = spin ? ST_FIN : ST_KB;
      end
      ST_KB: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = odm_pkg::MS_KB; state_d = ST_NUMB;
      end
      ST_NUMB: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = odm_pkg::MS_NUM; state_d = ST_DIB;
      end
      ST_DIB: begin
        cmd_o.div_init = 1'b1; cnt_d = '0; state_d = ST_DVB;
      end
      ST_DVB: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(odm_pkg::DIV_STEPS - 1)) begin
          cnt_d = '0; state_d = ST_SVB;
        end
      end
      ST_SVB: begin
        cmd_o.save_b = 1'b1; state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // checks on the sequencer
  `ODM_ASSERT_NEXT(a_load_decides, cmd_o.load, state_q == ST_DECIDE)
  `ODM_ASSERT_NEXT(a_finish_idles, cmd_o.finish, state_q == ST_IDLE)
  `ODM_ASSERT_IMPL(a_sq_count, state_q == ST_SQ, cnt_q < 5'(odm_pkg::SQ_STEPS))
  `ODM_ASSERT_IMPL(a_finish_free, cmd_o.finish, sts_i.out_free)

endmodule

/* rtl/odm_dp.sv */
// arithmetic datapath and result register of the omni drive mixer
`timescale 1ns / 1ps
module odm_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  odm_pkg::cfg_t       cfg_i,
  input  odm_pkg::cmd_t       cmd_i,
  output odm_pkg::sts_t       sts_o,
  input  logic                connected_i,
  input  logic signed [7:0]   stick_x_i,
  input  logic signed [7:0]   stick_y_i,
  input  logic [7:0]          right_trigger_i,
  input  logic [7:0]          left_trigger_i,
  input  logic                slow_button_i,
  input  logic                boost_up_button_i,
  input  logic                boost_down_button_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  motor1_current_o,
  output logic signed [15:0]  motor2_current_o,
  output logic signed [15:0]  motor3_current_o,
  output logic signed [15:0]  motor4_current_o,
  output logic [2:0]          drive_mode_o
);

  // latched request
  logic       conn_q, slow_q;
  logic [7:0] sx_q, sy_q, rt_q, lt_q;
  // block state
  logic       boost_q;
  logic [6:0] ramp_q;
  logic       out_valid_q;
  // working registers
  logic [15:0] d2_q;
  logic [14:0] t_q;
  logic [21:0] k_q;
  logic [30:0] t2_q;
  logic [odm_pkg::NUM_W-1:0] num_q, rem_q, dsh_q;
  logic [odm_pkg::DEN_W-1:0] den_q;
  logic [odm_pkg::SQ_W-1:0]  v_q, res_q, bit_q;
  logic [odm_pkg::QUO_W-1:0] quo_q;
  logic                      ovf_q;
  logic signed [15:0]        ca_q, cb_q;

  logic [7:0]  ax, ay, xz, yz, axz, ayz, rtz, ltz, trig;
  logic [6:0]  s, p;
  logic [8:0]  a, b, abs_a, abs_b;
  logic        spin;
  odm_pkg::kind_e kind;
  logic [31:0] mul_a;
  logic [19:0] mul_b;
  logic [51:0] prod;
  logic [15:0] d2m;
  logic [odm_pkg::SQ_W-1:0] trial;
  logic [14:0] mag;
  logic [15:0] cur_a, cur_b;
  logic [7:0]  ramp_sum;
  logic [6:0]  ramp_adv, ramp_def;

  // deadzones and mode choice
  always_comb begin
    ax    = sx_q[7] ? (~sx_q + 8'd1) : sx_q;
    ay    = sy_q[7] ? (~sy_q + 8'd1) : sy_q;
    xz    = (ax < cfg_i.stick_dz) ? 8'd0 : sx_q;
    yz    = (ay < cfg_i.stick_dz) ? 8'd0 : sy_q;
    axz   = xz[7] ? (~xz + 8'd1) : xz;
    ayz   = yz[7] ? (~yz + 8'd1) : yz;
    rtz   = (rt_q < cfg_i.trig_dz) ? 8'd0 : rt_q;
    ltz   = (lt_q < cfg_i.trig_dz) ? 8'd0 : lt_q;
    trig  = (rtz != 8'd0) ? rtz : ltz;
    s     = slow_q ? cfg_i.slow_factor : odm_pkg::PCT_FULL;
    p     = boost_q ? cfg_i.pwr_boost : cfg_i.pwr_norm;
    a     = {xz[7], xz} + {yz[7], yz};
    b     = {yz[7], yz} - {xz[7], xz};
    abs_a = a[8] ? (~a + 9'd1) : a;
    abs_b = b[8] ? (~b + 9'd1) : b;
    if (!conn_q) kind = odm_pkg::KIND_DISC;
    else if ((rtz != 8'd0 && ltz != 8'd0) ||
             (rtz == 8'd0 && ltz == 8'd0 && xz == 8'd0 && yz == 8'd0))
      kind = odm_pkg::KIND_STOP;
    else if (rtz != 8'd0 || ltz != 8'd0) kind = odm_pkg::KIND_SPIN;
    else kind = odm_pkg::KIND_TRANS;
  end

  assign spin           = (kind == odm_pkg::KIND_SPIN);
  assign sts_o.kind     = kind;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // shared multiplier operand select
  always_comb begin
    unique case (cmd_i.mul_sel)
      odm_pkg::MS_XX: begin mul_a = 32'(axz); mul_b = 20'(axz); end
      odm_pkg::MS_YY: begin mul_a = 32'(ayz); mul_b = 20'(ayz); end
      odm_pkg::MS_K1: begin
        mul_a = spin ? 32'(trig) : 32'(p);
        mul_b = spin ? 20'(cfg_i.turn_pwr) : 20'(ramp_q);
      end
      odm_pkg::MS_KS: begin mul_a = 32'(t_q); mul_b = 20'(s); end
      odm_pkg::MS_KA: begin mul_a = 32'(k_q); mul_b = 20'(abs_a); end
      odm_pkg::MS_KB: begin mul_a = 32'(k_q); mul_b = 20'(abs_b); end
      odm_pkg::MS_NUM: begin
        mul_a = spin ? 32'(k_q) : 32'(t2_q);
        mul_b = 20'(odm_pkg::FULL_SCALE);
      end
      odm_pkg::MS_DEN: begin mul_a = 32'(res_q[24:0]); mul_b = odm_pkg::SQRT_SCALE; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod  = 52'(mul_a) * 52'(mul_b);
  assign d2m   = (d2_q < odm_pkg::D2_MIN) ? odm_pkg::D2_MIN : d2_q;
  assign trial = res_q + bit_q;

  // saturated magnitudes with sign
  always_comb begin
    mag   = (ovf_q || quo_q > odm_pkg::FULL_SCALE) ? odm_pkg::FULL_SCALE : quo_q;
    cur_a = (spin ? (rtz == 8'd0) : a[8]) ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
    cur_b = b[8] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
  end

  // ramp stepping
  always_comb begin
    ramp_sum = {1'b0, ramp_q} + {1'b0, cfg_i.ramp_step};
    ramp_adv = (ramp_sum > {1'b0, odm_pkg::RAMP_MAX}) ? odm_pkg::RAMP_MAX : ramp_sum[6:0];
    ramp_def = (cfg_i.ramp_default > odm_pkg::RAMP_MAX) ? odm_pkg::RAMP_MAX
                                                        : cfg_i.ramp_default;
  end

  // request capture, multiplier, square root and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      conn_q <= connected_i;
      sx_q   <= stick_x_i;
      sy_q   <= stick_y_i;
      rt_q   <= right_trigger_i;
      lt_q   <= left_trigger_i;
      slow_q <= slow_button_i;
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        odm_pkg::MS_XX:  d2_q <= prod[15:0];
        odm_pkg::MS_YY:  d2_q <= d2_q + prod[15:0];
        odm_pkg::MS_K1:  t_q  <= prod[14:0];
        odm_pkg::MS_KS:  k_q  <= prod[21:0];
        odm_pkg::MS_KA:  t2_q <= prod[30:0];
        odm_pkg::MS_KB:  t2_q <= prod[30:0];
        odm_pkg::MS_NUM: num_q <= spin ? odm_pkg::NUM_W'(prod) : {prod[45:0], 16'd0};
        odm_pkg::MS_DEN: den_q <= spin ? odm_pkg::DEN_W'(odm_pkg::DEN_SPIN) : prod[44:0];
        default: ;
      endcase
    end
    if (cmd_i.sq_init) begin
      v_q   <= {1'b0, d2m, 33'd0};
      res_q <= '0;
      bit_q <= odm_pkg::SQ_W'(1) << 48;
    end else if (cmd_i.sq_step) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.div_init) begin
      rem_q <= num_q;
      dsh_q <= {3'd0, den_q, 14'd0};
      ovf_q <= num_q >= {2'd0, den_q, 15'd0};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[13:0], 1'b1};
      end else begin
        quo_q <= {quo_q[13:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.save_a) ca_q <= cur_a;
    if (cmd_i.save_b) cb_q <= cur_b;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      unique case (kind)
        odm_pkg::KIND_SPIN: begin
          motor1_current_o <= ca_q; motor2_current_o <= ca_q;
          motor3_current_o <= ca_q; motor4_current_o <= ca_q;
          drive_mode_o <= (rtz != 8'd0) ? odm_pkg::MODE_RSPIN : odm_pkg::MODE_LSPIN;
        end
        odm_pkg::KIND_TRANS: begin
          motor1_current_o <= cb_q; motor2_current_o <= -ca_q;
          motor3_current_o <= ca_q; motor4_current_o <= -cb_q;
          drive_mode_o <= odm_pkg::MODE_TRANS;
        end
        odm_pkg::KIND_STOP: begin
          motor1_current_o <= '0; motor2_current_o <= '0;
          motor3_current_o <= '0; motor4_current_o <= '0;
          drive_mode_o <= odm_pkg::MODE_STOP;
        end
        default: begin
          motor1_current_o <= '0; motor2_current_o <= '0;
          motor3_current_o <= '0; motor4_current_o <= '0;
          drive_mode_o <= odm_pkg::MODE_DISC;
        end
      endcase
    end
  end

  // boost, ramp and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boost_q     <= 1'b0;
      ramp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && connected_i) begin
        if (boost_up_button_i) boost_q <= 1'b1;
        else if (boost_down_button_i) boost_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        if (kind == odm_pkg::KIND_STOP) ramp_q <= ramp_def;
        else if (kind != odm_pkg::KIND_DISC) ramp_q <= ramp_adv;
      end
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* tb/omni_drive_mixer_tb.sv */
// self-checking testbench for the omni drive mixer
`timescale 1ns / 1ps
module omni_drive_mixer_tb;

  typedef struct packed {
    logic       connected;
    logic [7:0] sx;
    logic [7:0] sy;
    logic [7:0] rt;
    logic [7:0] lt;
    logic       slow;
    logic       bup;
    logic       bdn;
  } pad_t;

  typedef struct packed {
    logic [15:0] m1;
    logic [15:0] m2;
    logic [15:0] m3;
    logic [15:0] m4;
    logic [2:0]  mode;
  } wheels_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic connected_i = 1'b0;
  logic signed [7:0] stick_x_i = '0;
  logic signed [7:0] stick_y_i = '0;
  logic [7:0] right_trigger_i = '0;
  logic [7:0] left_trigger_i = '0;
  logic slow_button_i = 1'b0;
  logic boost_up_button_i = 1'b0;
  logic boost_down_button_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] motor1_current_o, motor2_current_o;
  logic signed [15:0] motor3_current_o, motor4_current_o;
  logic [2:0] drive_mode_o;

  omni_drive_mixer dut (.*);

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copies of registers and state
  logic [7:0] p_stick_dz, p_trig_dz;
  logic [6:0] p_turn, p_norm, p_boost, p_slow, p_rstep, p_rdef;
  int unsigned ramp_pct;
  bit boost_on;

  pad_t pending_pads[$];
  wheels_t expected_wheels[$];
  int errors = 0;
  int accepted = 0;
  bit quiet_tail = 0;
  bit hold_out = 0;

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] clamp_cur(input longint unsigned mag, input bit neg);
    longint signed v;
    if (mag > 16384) mag = 16384;
    v = neg ? -longint'(mag) : longint'(mag);
    return v[15:0];
  endfunction

  function automatic void ramp_up();
    ramp_pct = ramp_pct + p_rstep;
    if (ramp_pct > 100) ramp_pct = 100;
  endfunction

  // compute the wheel currents for one pad sample and, if connected, update ramp and boost
  function automatic wheels_t mix_pad(input pad_t pd);
    wheels_t w;
    int x, y, a, b;
    int unsigned rt, lt, s, t, pw;
    longint unsigned d2, q, k, den, ma, mb, mag;
    w = '0;
    if (!pd.connected) begin
      w.mode = odm_pkg::MODE_DISC;
      return w;
    end
    x = $signed(pd.sx);
    y = $signed(pd.sy);
    rt = pd.rt;
    lt = pd.lt;
    if ((x < 0 ? -x : x) < p_stick_dz) x = 0;
    if ((y < 0 ? -y : y) < p_stick_dz) y = 0;
    if (rt < p_trig_dz) rt = 0;
    if (lt < p_trig_dz) lt = 0;
    s = pd.slow ? p_slow : 100;
    if (pd.bup) boost_on = 1;
    else if (pd.bdn) boost_on = 0;
    if ((rt > 0 && lt > 0) || (rt == 0 && lt == 0 && x == 0 && y == 0)) begin
      w.mode = odm_pkg::MODE_STOP;
      ramp_pct = p_rdef > 100 ? 100 : p_rdef;
    end else if (rt > 0 || lt > 0) begin
      t = rt > 0 ? rt : lt;
      mag = 64'd16384 * t * p_turn * s / 64'd2550000;
      w.m1 = clamp_cur(mag, rt == 0);
      w.m2 = w.m1;
      w.m3 = w.m1;
      w.m4 = w.m1;
      w.mode = rt > 0 ? odm_pkg::MODE_RSPIN : odm_pkg::MODE_LSPIN;
      ramp_up();
    end else begin
      pw = boost_on ? p_boost : p_norm;
      d2 = x * x + y * y;
      if (d2 < 16129) d2 = 16129;
      a = x + y;
      b = y - x;
      q = int_sqrt((2 * d2) << 32);
      k = 64'd16384 * pw * ramp_pct * s;
      den = 64'd1000000 * q;
      ma = ((k * (a < 0 ? -a : a)) << 16) / den;
      mb = ((k * (b < 0 ? -b : b)) << 16) / den;
      w.m3 = clamp_cur(ma, a < 0);
      w.m2 = clamp_cur(ma, a >= 0 && ma != 0);
      w.m1 = clamp_cur(mb, b < 0);
      w.m4 = clamp_cur(mb, b >= 0 && mb != 0);
      w.mode = odm_pkg::MODE_TRANS;
      ramp_up();
    end
    return w;
  endfunction

  // request driver
  int in_gap = 0;
  always @(negedge clk_i) begin
    if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i && in_ready_o) begin
        pending_pads.pop_front();
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 17) - 1;
        in_valid_i <= 1'b0;
      end else if ((in_valid_i && in_ready_o ? pending_pads.size() > 1
                    : pending_pads.size() > 0)) begin
        pad_t pd;
        pd = (in_valid_i && in_ready_o) ? pending_pads[1] : pending_pads[0];
        in_valid_i <= 1'b1;
        connected_i <= pd.connected;
        stick_x_i <= pd.sx;
        stick_y_i <= pd.sy;
        right_trigger_i <= pd.rt;
        left_trigger_i <= pd.lt;
        slow_button_i <= pd.slow;
        boost_up_button_i <= pd.bup;
        boost_down_button_i <= pd.bdn;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stalls
  int out_gap = 0;
  always @(negedge clk_i) begin
    if (hold_out) begin
      out_ready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(1, 17) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pad_t pd;
        pd = {connected_i, stick_x_i, stick_y_i, right_trigger_i, left_trigger_i,
              slow_button_i, boost_up_button_i, boost_down_button_i};
        expected_wheels.push_back(mix_pad(pd));
        accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_wheels.size() == 0) begin
          report("unexpected result", 16'(drive_mode_o), 16'd0);
        end else begin
          wheels_t e;
          e = expected_wheels.pop_front();
          if (drive_mode_o !== e.mode)
            report("drive_mode", 16'(drive_mode_o), 16'(e.mode));
          if (motor1_current_o !== e.m1) report("motor1", motor1_current_o, e.m1);
          if (motor2_current_o !== e.m2) report("motor2", motor2_current_o, e.m2);
          if (motor3_current_o !== e.m3) report("motor3", motor3_current_o, e.m3);
          if (motor4_current_o !== e.m4) report("motor4", motor4_current_o, e.m4);
        end
      end
    end
  end

  // register write, only while idle
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      odm_pkg::CFG_STICK_DZ:  p_stick_dz = val;
      odm_pkg::CFG_TRIG_DZ:   p_trig_dz = val;
      odm_pkg::CFG_TURN_PWR:  p_turn = val[6:0];
      odm_pkg::CFG_PWR_NORM:  p_norm = val[6:0];
      odm_pkg::CFG_PWR_BOOST: p_boost = val[6:0];
      odm_pkg::CFG_SLOW:      p_slow = val[6:0];
      odm_pkg::CFG_RAMP_STEP: p_rstep = val[6:0];
      odm_pkg::CFG_RAMP_DEF:  p_rdef = val[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_pads.size() > 0 || in_valid_i || expected_wheels.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic pad_t rand_pad(input int style);
    pad_t pd;
    pd = pad_t'({$urandom, $urandom});
    pd.connected = ($urandom_range(0, 15) != 0);
    case (style)
      0: begin
        pd.rt = 0;
        pd.lt = 0;
      end
      1: begin
        if ($urandom_range(0, 1)) pd.rt = 0; else pd.lt = 0;
        pd.sx = 0;
      end
      default: ;
    endcase
    return pd;
  endfunction

  function automatic pad_t mk(input logic c, input int sx, input int sy,
                              input int rt, input int lt, input logic sl,
                              input logic bu, input logic bd);
    pad_t pd;
    pd = {c, sx[7:0], sy[7:0], rt[7:0], lt[7:0], sl, bu, bd};
    return pd;
  endfunction

  // pressure: long receiver hold-off while requests keep coming
  initial begin
    wait (accepted > 300);
    hold_out = 1;
    repeat (600) @(posedge clk_i);
    hold_out = 0;
  end

  // stimulus
  initial begin
    p_stick_dz = 40; p_trig_dz = 40; p_turn = 30; p_norm = 70;
    p_boost = 100; p_slow = 30; p_rstep = 1; p_rdef = 25;
    ramp_pct = 0; boost_on = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: disconnect, stop, spins, stick extremes, boost, slow
    pending_pads.push_back(mk(0, 127, 127, 255, 0, 1, 1, 0));
    pending_pads.push_back(mk(1, -128, 127, 0, 0, 0, 0, 0));
    pending_pads.push_back(mk(1, -128, -128, 0, 0, 0, 0, 0));
    pending_pads.push_back(mk(1, 127, -128, 0, 0, 1, 0, 0));
    pending_pads.push_back(mk(1, 0, 0, 255, 0, 0, 0, 0));
    pending_pads.push_back(mk(1, 0, 0, 0, 255, 1, 0, 0));
    pending_pads.push_back(mk(1, 0, 0, 255, 255, 0, 0, 0));
    pending_pads.push_back(mk(1, 39, -39, 39, 39, 0, 0, 0));
    pending_pads.push_back(mk(1, 40, 0, 0, 40, 0, 1, 0));
    pending_pads.push_back(mk(1, 127, 0, 0, 0, 0, 0, 1));
    pending_pads.push_back(mk(1, 60, 60, 0, 0, 0, 1, 1));
    pending_pads.push_back(mk(1, -60, 90, 0, 0, 1, 0, 1));
    pending_pads.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // extreme settings: zero deadzones, full powers, big ramp steps
    write_reg(odm_pkg::CFG_STICK_DZ, 8'd0);
    write_reg(odm_pkg::CFG_TRIG_DZ, 8'd0);
    write_reg(odm_pkg::CFG_TURN_PWR, 8'd100);
    write_reg(odm_pkg::CFG_PWR_NORM, 8'd100);
    write_reg(odm_pkg::CFG_PWR_BOOST, 8'd127);
    write_reg(odm_pkg::CFG_SLOW, 8'd100);
    write_reg(odm_pkg::CFG_RAMP_STEP, 8'd127);
    write_reg(odm_pkg::CFG_RAMP_DEF, 8'd127);
    for (int i = 0; i < 350; i++) pending_pads.push_back(rand_pad($urandom_range(0, 3)));
    wait_drained();

    // the other end: largest deadzones, zero turn and normal powers
    write_reg(odm_pkg::CFG_STICK_DZ, 8'd255);
    write_reg(odm_pkg::CFG_TRIG_DZ, 8'd255);
    write_reg(odm_pkg::CFG_TURN_PWR, 8'd0);
    write_reg(odm_pkg::CFG_PWR_NORM, 8'd0);
    write_reg(odm_pkg::CFG_SLOW, 8'd0);
    write_reg(odm_pkg::CFG_RAMP_STEP, 8'd0);
    write_reg(odm_pkg::CFG_RAMP_DEF, 8'd0);
    for (int i = 0; i < 100; i++) pending_pads.push_back(rand_pad($urandom_range(0, 3)));
    wait_drained();

    // several random settings
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(odm_pkg::CFG_STICK_DZ, 8'($urandom_range(0, 128)));
      write_reg(odm_pkg::CFG_TRIG_DZ, 8'($urandom_range(0, 255)));
      write_reg(odm_pkg::CFG_TURN_PWR, 8'($urandom_range(0, 127)));
      write_reg(odm_pkg::CFG_PWR_NORM, 8'($urandom_range(0, 127)));
      write_reg(odm_pkg::CFG_PWR_BOOST, 8'($urandom_range(0, 127)));
      write_reg(odm_pkg::CFG_SLOW, 8'($urandom_range(0, 127)));
      write_reg(odm_pkg::CFG_RAMP_STEP, 8'($urandom_range(0, 127)));
      write_reg(odm_pkg::CFG_RAMP_DEF, 8'($urandom_range(0, 127)));
      if (ph == 3) quiet_tail = 1;
      for (int i = 0; i < 250; i++) pending_pads.push_back(rand_pad($urandom_range(0, 3)));
      wait_drained();
    end

    if (errors == 0) begin
      $display("omni_drive_mixer_tb: PASS");
    end else begin
      $display("omni_drive_mixer_tb: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("omni_drive_mixer_tb: FAIL");
    $finish;
  end

endmodule
